// ===== rtl/kli_pkg.sv =====
// Shared types, field layout and constants for the keyframe interpolator.
package kli_pkg;

  localparam int TIME_W     = 24;
  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 8;
  localparam int COUNT_W    = 9;
  localparam int FRAC_W     = 16;
  localparam int BLEND_W    = FRAC_W + 1;
  localparam int COMP_N     = 3;

  localparam int DEFAULT_MAX_KEYS = 256;

  localparam logic [BLEND_W-1:0] ONE_Q16 = BLEND_W'(1) << FRAC_W;

  // command codes carried in in_tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // input item layout
  localparam int IN_USER_W   = 1;
  localparam int KIDX_LSB    = 0;
  localparam int KTIME_LSB   = KIDX_LSB + INDEX_W;
  localparam int VAL_LSB     = KTIME_LSB + TIME_W;
  localparam int QTIME_LSB   = VAL_LSB + COMP_N * VALUE_W;
  localparam int IN_USED_W   = QTIME_LSB + TIME_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // result item layout
  localparam int SEG_LSB     = COMP_N * VALUE_W;
  localparam int BLEND_LSB   = SEG_LSB + INDEX_W;
  localparam int OUT_USED_W  = BLEND_LSB + BLEND_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  typedef logic [COMP_N-1:0][VALUE_W-1:0] vec3_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH0,
    ST_FETCH1,
    ST_FACTOR,
    ST_DECIDE,
    ST_DIV,
    ST_LERP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    LP_IDLE,
    LP_DELTA,
    LP_MUL,
    LP_ADD
  } lerp_ph_t;

endpackage

// ===== rtl/kli_table.sv =====
// Keyframe storage: time memory and value memory, one write and one read port.
module kli_table #(
  parameter int MAX_KEYS = kli_pkg::DEFAULT_MAX_KEYS
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(MAX_KEYS)-1:0] wr_addr,
  input  logic [kli_pkg::TIME_W-1:0]  wr_time,
  input  kli_pkg::vec3_t              wr_value,
  input  logic                        rd_en,
  input  logic [$clog2(MAX_KEYS)-1:0] rd_addr,
  output logic [kli_pkg::TIME_W-1:0]  rd_time,
  output kli_pkg::vec3_t              rd_value
);
  import kli_pkg::*;

  logic [TIME_W-1:0] time_mem [MAX_KEYS];
  vec3_t             value_mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= wr_time;
    end
    if (rd_en) begin
      rd_time <= time_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[wr_addr] <= wr_value;
    end
    if (rd_en) begin
      rd_value <= value_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/kli_div.sv =====
// Restoring divider: one quotient bit per cycle, num < den, Q0.16 result.
module kli_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [kli_pkg::TIME_W-1:0] num,
  input  logic [kli_pkg::TIME_W-1:0] den,
  output logic                       done,
  output logic [kli_pkg::FRAC_W-1:0] quot
);
  import kli_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] den_r;
  logic [FRAC_W-1:0] quot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;

  logic [TIME_W:0]   rem2;
  logic [TIME_W:0]   diff;
  logic              ge;

  assign rem2 = {rem_r, 1'b0};
  assign diff = rem2 - {1'b0, den_r};
  assign ge   = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(FRAC_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (run_r) begin
      rem_r  <= ge ? diff[TIME_W-1:0] : rem2[TIME_W-1:0];
      quot_r <= {quot_r[FRAC_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== rtl/kli_lerp.sv =====
// Blend unit: one shared multiplier, three components in turn.
module kli_lerp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [kli_pkg::BLEND_W-1:0] factor,
  input  kli_pkg::vec3_t              start_val,
  input  kli_pkg::vec3_t              end_val,
  output logic                        done,
  output kli_pkg::vec3_t              result
);
  import kli_pkg::*;

  localparam int MW = VALUE_W + 1;
  localparam int PW = MW + BLEND_W;

  lerp_ph_t          ph_r, ph_nxt;
  logic [1:0]        comp_r;
  logic              neg_r;
  logic [MW-1:0]     mag_r;
  logic [PW-1:0]     prod_r;
  vec3_t             res_r;

  logic [VALUE_W-1:0] s_c;
  logic [VALUE_W-1:0] e_c;
  logic [MW-1:0]      delta;
  logic [MW-1:0]      step;
  logic [MW-1:0]      sum;
  logic               last;

  assign s_c   = start_val[comp_r];
  assign e_c   = end_val[comp_r];
  assign delta = {e_c[VALUE_W-1], e_c} - {s_c[VALUE_W-1], s_c};
  assign step  = prod_r[FRAC_W +: MW];
  assign sum   = neg_r ? ({s_c[VALUE_W-1], s_c} - step) : ({s_c[VALUE_W-1], s_c} + step);
  assign last  = comp_r == 2'(COMP_N - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= LP_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_comb begin
    ph_nxt = ph_r;
    done   = 1'b0;
    case (ph_r)
      LP_IDLE:  if (start) ph_nxt = LP_DELTA;
      LP_DELTA: ph_nxt = LP_MUL;
      LP_MUL:   ph_nxt = LP_ADD;
      LP_ADD: begin
        if (last) begin
          done   = 1'b1;
          ph_nxt = LP_IDLE;
        end else begin
          ph_nxt = LP_DELTA;
        end
      end
      default:  ph_nxt = LP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (ph_r)
      LP_IDLE: comp_r <= '0;
      LP_DELTA: begin
        neg_r <= delta[MW-1];
        mag_r <= delta[MW-1] ? (~delta + MW'(1)) : delta;
      end
      LP_MUL: prod_r <= PW'(mag_r) * PW'(factor);
      LP_ADD: begin
        res_r[comp_r] <= sum[VALUE_W-1:0];
        comp_r        <= comp_r + 2'(1);
      end
      default: comp_r <= '0;
    endcase
  end

  assign result = res_r;

endmodule

// ===== rtl/keyframe_linear_interpolator.sv =====
// Keyframe linear interpolator top: key table, segment scan, factor divide, blend.
// Write item: stored at the accept edge, no result.
// Query item: a scan of the key times from index 1 up to n-1 (skipped with one key), a fetch of both
// segment keys, the factor, a divide only when the factor lies strictly between 0 and 1, then the blend.
// One query at a time: in_tready returns the cycle after the result is loaded.
// Reset clears control and sets key_count to 1; the key tables are not cleared.
module keyframe_linear_interpolator #(
  parameter int MAX_KEYS = kli_pkg::DEFAULT_MAX_KEYS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input item stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: key_index, key_time, value_x, value_y, value_z, query_time
  input  logic [kli_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: command
  input  logic [kli_pkg::IN_USER_W-1:0]  in_tuser,
  // result item stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata: out_x, out_y, out_z, segment, blend, zero pad
  output logic [kli_pkg::OUT_DATA_W-1:0] out_tdata,
  // key_count register write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kli_pkg::COUNT_W-1:0]    cfg_data
);
  import kli_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);        // table address
  localparam int CW = $clog2(MAX_KEYS + 1);    // holds a key count up to MAX_KEYS
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [XW-1:0] MAXK = XW'(MAX_KEYS);

  // ---------------------------------------------------------------- config
  logic [COUNT_W-1:0] kc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kc_r <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      kc_r <= cfg_data;
    end
  end

  // effective key count: zero acts as one, clipped to table depth
  logic [XW-1:0] kc_w;
  logic [XW-1:0] n_w;
  logic          n_single;

  assign kc_w     = XW'(kc_r);
  assign n_w      = (kc_w == '0) ? XW'(1) : ((kc_w > MAXK) ? MAXK : kc_w);
  assign n_single = n_w == XW'(1);

  // ---------------------------------------------------------------- input fields
  logic [XW-1:0]     kidx_w;
  logic              wr_ok;
  logic [TIME_W-1:0] key_time;
  logic [TIME_W-1:0] query_time;
  vec3_t             key_value;

  assign kidx_w     = XW'(in_tdata[KIDX_LSB +: INDEX_W]);
  assign wr_ok      = kidx_w < MAXK;          // slots past the table are dropped
  assign key_time   = in_tdata[KTIME_LSB +: TIME_W];
  assign key_value  = in_tdata[VAL_LSB +: COMP_N * VALUE_W];
  assign query_time = in_tdata[QTIME_LSB +: TIME_W];

  // ---------------------------------------------------------------- state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     n_r;
  logic              single_r;
  logic [TIME_W-1:0] qt_r;
  logic [AW-1:0]     scan_r;       // next address to read during the scan
  logic [AW-1:0]     pend_addr_r;  // address whose data is on the read port
  logic              pend_r;
  logic [AW-1:0]     seg_r;
  logic [TIME_W-1:0] t1_r;
  vec3_t             s_r;
  vec3_t             e_r;
  logic [TIME_W:0]   num_r;        // qt - t1, two's complement
  logic [TIME_W:0]   den_r;        // t2 - t1
  logic [BLEND_W-1:0] factor_r;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // memory ports
  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [TIME_W-1:0] rd_time;
  vec3_t             rd_value;

  // unit handshakes
  logic              div_start;
  logic              div_done;
  logic [FRAC_W-1:0] div_quot;
  logic              lerp_start;
  logic              lerp_done;
  vec3_t             lerp_res;
  logic              out_load;

  logic [CW-1:0]     nm1_w;
  logic [AW-1:0]     nm1;
  logic              scan_hit;
  logic              scan_end;

  assign nm1_w    = n_r - CW'(1);
  assign nm1      = nm1_w[AW-1:0];
  assign scan_hit = pend_r && (qt_r < rd_time);
  assign scan_end = pend_r && (pend_addr_r == nm1);

  // ---------------------------------------------------------------- factor decision
  logic [TIME_W:0]    num_abs;
  logic [TIME_W:0]    den_abs;
  logic [TIME_W-1:0]  an;
  logic [TIME_W-1:0]  ad;
  logic               need_div;
  logic [BLEND_W-1:0] fac_dec;

  assign num_abs = num_r[TIME_W] ? (~num_r + (TIME_W+1)'(1)) : num_r;
  assign den_abs = den_r[TIME_W] ? (~den_r + (TIME_W+1)'(1)) : den_r;
  assign an      = num_abs[TIME_W-1:0];
  assign ad      = den_abs[TIME_W-1:0];

  always_comb begin
    need_div = 1'b0;
    fac_dec  = '0;
    if (single_r) begin
      fac_dec = '0;
    end else if (den_r == '0) begin
      // flat segment: step to one once past the key time
      fac_dec = (!num_r[TIME_W] && num_r != '0) ? ONE_Q16 : '0;
    end else if (num_r == '0 || num_r[TIME_W] != den_r[TIME_W]) begin
      fac_dec = '0;
    end else if (an >= ad) begin
      fac_dec = ONE_Q16;
    end else begin
      need_div = 1'b1;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = scan_r;
    div_start  = 1'b0;
    lerp_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser[0] == CMD_WRITE) begin
            wr_en = wr_ok;
          end else begin
            state_nxt = n_single ? ST_FETCH0 : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_r;
        if (scan_hit || scan_end) begin
          state_nxt = ST_FETCH0;
        end
      end
      ST_FETCH0: begin
        rd_en     = 1'b1;
        rd_addr   = seg_r;
        state_nxt = ST_FETCH1;
      end
      ST_FETCH1: begin
        rd_en     = 1'b1;
        rd_addr   = seg_r + AW'(1);
        state_nxt = ST_FACTOR;
      end
      ST_FACTOR: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (need_div) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          lerp_start = 1'b1;
          state_nxt  = ST_LERP;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          lerp_start = 1'b1;
          state_nxt  = ST_LERP;
        end
      end
      ST_LERP: begin
        if (lerp_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= state_r == ST_SCAN && !(scan_hit || scan_end);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tuser[0] == CMD_QUERY) begin
          n_r      <= n_w[CW-1:0];
          single_r <= n_single;
          qt_r     <= query_time;
          seg_r    <= '0;
          scan_r   <= AW'(1);
        end
      end
      ST_SCAN: begin
        pend_addr_r <= scan_r;
        if (scan_r != nm1) begin
          scan_r <= scan_r + AW'(1);
        end
        if (scan_hit) begin
          seg_r <= pend_addr_r - AW'(1);
        end else if (scan_end) begin
          seg_r <= '0;    // no later key: fall back to the first segment
        end
      end
      ST_FETCH1: begin
        t1_r <= rd_time;
        s_r  <= rd_value;
      end
      ST_FACTOR: begin
        e_r   <= single_r ? s_r : rd_value;
        num_r <= {1'b0, qt_r} - {1'b0, t1_r};
        den_r <= {1'b0, rd_time} - {1'b0, t1_r};
      end
      ST_DECIDE: begin
        if (!need_div) begin
          factor_r <= fac_dec;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          factor_r <= {1'b0, div_quot};
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- units
  kli_table #(
    .MAX_KEYS (MAX_KEYS)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (kidx_w[AW-1:0]),
    .wr_time  (key_time),
    .wr_value (key_value),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_time  (rd_time),
    .rd_value (rd_value)
  );

  kli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (an),
    .den   (ad),
    .done  (div_done),
    .quot  (div_quot)
  );

  kli_lerp u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (lerp_start),
    .factor    (factor_r),
    .start_val (s_r),
    .end_val   (e_r),
    .done      (lerp_done),
    .result    (lerp_res)
  );

  // ---------------------------------------------------------------- output register
  logic [XW-1:0]      seg_w;

  assign seg_w = XW'(seg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= OUT_DATA_W'({factor_r, seg_w[INDEX_W-1:0], lerp_res});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------------------------------------------------------- checks
  a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[BLEND_LSB +: BLEND_W] <= ONE_Q16))
    else $error("blend above one");

  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == CMD_WRITE && !out_tvalid) |=> !out_tvalid)
    else $error("write item produced a result");

  a_seg_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH0) |-> (XW'(seg_r) < XW'(n_r)))
    else $error("segment beyond key count");

  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide state");

endmodule
